>>> design/lcdseq_pkg.sv
`default_nettype none

package lcdseq_pkg;

    localparam int DOT_W  = 10;
    localparam int LINE_W = 8;
    localparam int CFG_W  = 10;
    localparam int IDX_W  = 3;

    typedef enum logic [1:0] {
        MODE_HORIZ_BLANK = 2'd0,
        MODE_VERT_BLANK  = 2'd1,
        MODE_SEARCH      = 2'd2,
        MODE_TRANSFER    = 2'd3
    } mode_t;

    typedef enum logic [IDX_W-1:0] {
        REG_HBLANK_LENGTH      = 3'd0,
        REG_VBLANK_LINE_LENGTH = 3'd1,
        REG_SEARCH_LENGTH      = 3'd2,
        REG_TRANSFER_LENGTH    = 3'd3,
        REG_VISIBLE_LINES      = 3'd4,
        REG_FINAL_LINE         = 3'd5
    } reg_index_t;

    localparam logic [DOT_W-1:0]  HBLANK_LENGTH_RST      = 10'd204;
    localparam logic [DOT_W-1:0]  VBLANK_LINE_LENGTH_RST = 10'd456;
    localparam logic [DOT_W-1:0]  SEARCH_LENGTH_RST      = 10'd80;
    localparam logic [DOT_W-1:0]  TRANSFER_LENGTH_RST    = 10'd172;
    localparam logic [LINE_W-1:0] VISIBLE_LINES_RST      = 8'd144;
    localparam logic [LINE_W-1:0] FINAL_LINE_RST         = 8'd153;

endpackage

`default_nettype wire

>>> design/lcd_mode_line_sequencer_top.sv
// Channel   Dir  Handshake                   Payload (low bit first)
// s_axis    in   s_axis_tvalid/tready        tdata[0] advance, [7:1] zero
// m_axis    out  m_axis_tvalid/tready        tdata[1:0] screen_mode, [9:2] line_number,
//                                            [10] vblank_irq, [15:11] zero
// cfg       in   cfg_we (no wait)            cfg_index selects register, cfg_data value
//
// One tick per cycle unless stalled: each transaction updates the dot counter,
// mode and line in the cycle it is accepted and loads the result register on the same edge.
// The result register is the only buffer: input is taken while it is empty or
// being drained, so a stalled output stalls the input with no bubble after it.
// Reset (rst_n low, asynchronous) restores register defaults, search mode, line 0.
`default_nettype none

module lcd_mode_line_sequencer_top
    import lcdseq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [7:0]        s_axis_tdata,   // [0] advance
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [15:0]            m_axis_tdata,   // [1:0] screen_mode, [9:2] line_number,
                                                   // [10] vblank_irq
    input  wire logic              cfg_we,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data
);

    logic [DOT_W-1:0]  hblank_length_reg;
    logic [DOT_W-1:0]  vblank_line_length_reg;
    logic [DOT_W-1:0]  search_length_reg;
    logic [DOT_W-1:0]  transfer_length_reg;
    logic [LINE_W-1:0] visible_lines_reg;
    logic [LINE_W-1:0] final_line_reg;

    logic [DOT_W-1:0]  dot_reg, dot_next;
    mode_t             mode_reg, mode_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic              irq_next;

    logic              out_valid_reg;
    mode_t             res_mode_reg;
    logic [LINE_W-1:0] res_line_reg;
    logic              res_irq_reg;

    logic              s_fire;
    logic [DOT_W:0]    dot_inc;
    logic [DOT_W-1:0]  mode_len;
    logic [LINE_W-1:0] line_inc;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hblank_length_reg      <= HBLANK_LENGTH_RST;
            vblank_line_length_reg <= VBLANK_LINE_LENGTH_RST;
            search_length_reg      <= SEARCH_LENGTH_RST;
            transfer_length_reg    <= TRANSFER_LENGTH_RST;
            visible_lines_reg      <= VISIBLE_LINES_RST;
            final_line_reg         <= FINAL_LINE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HBLANK_LENGTH:      hblank_length_reg      <= cfg_data;
                REG_VBLANK_LINE_LENGTH: vblank_line_length_reg <= cfg_data;
                REG_SEARCH_LENGTH:      search_length_reg      <= cfg_data;
                REG_TRANSFER_LENGTH:    transfer_length_reg    <= cfg_data;
                REG_VISIBLE_LINES:      visible_lines_reg      <= cfg_data[LINE_W-1:0];
                REG_FINAL_LINE:         final_line_reg         <= cfg_data[LINE_W-1:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        case (mode_reg)
            MODE_HORIZ_BLANK: mode_len = hblank_length_reg;
            MODE_VERT_BLANK:  mode_len = vblank_line_length_reg;
            MODE_SEARCH:      mode_len = search_length_reg;
            default:          mode_len = transfer_length_reg;
        endcase
    end

    assign dot_inc  = {1'b0, dot_reg} + {{DOT_W{1'b0}}, 1'b1};
    assign line_inc = line_reg + {{(LINE_W-1){1'b0}}, 1'b1};

    always_comb
    begin
        dot_next  = dot_reg;
        mode_next = mode_reg;
        line_next = line_reg;
        irq_next  = 1'b0;
        if (s_axis_tdata[0])
        begin
            if (dot_inc > {1'b0, mode_len})
            begin
                // end of mode: carry the overshoot into the next one
                dot_next = dot_inc[DOT_W-1:0] - mode_len;
                case (mode_reg)
                    MODE_SEARCH:   mode_next = MODE_TRANSFER;
                    MODE_TRANSFER: mode_next = MODE_HORIZ_BLANK;
                    MODE_HORIZ_BLANK:
                    begin
                        line_next = line_inc;
                        mode_next = (line_inc >= visible_lines_reg) ? MODE_VERT_BLANK
                                                                    : MODE_SEARCH;
                    end
                    default:
                    begin
                        if (line_reg >= final_line_reg)
                        begin
                            line_next = '0;
                            mode_next = MODE_SEARCH;
                            irq_next  = 1'b1;
                        end
                        else
                        begin
                            line_next = line_inc;
                        end
                    end
                endcase
            end
            else
            begin
                dot_next = dot_inc[DOT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg       <= '0;
            mode_reg      <= MODE_SEARCH;
            line_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_fire)
            begin
                dot_reg       <= dot_next;
                mode_reg      <= mode_next;
                line_reg      <= line_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            res_mode_reg <= mode_next;
            res_line_reg <= line_next;
            res_irq_reg  <= irq_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, res_irq_reg, res_line_reg, res_mode_reg};

`ifndef SYNTHESIS
    a_irq_wraps_to_search: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_irq_reg) |-> (res_mode_reg == MODE_SEARCH && res_line_reg == '0))
        else $error("vblank irq without wrap to line 0 in search mode");

    a_hold_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && !s_axis_tdata[0]) |=>
            (res_mode_reg == $past(mode_reg) && res_line_reg == $past(line_reg)
             && !res_irq_reg && $stable(dot_reg)))
        else $error("held tick changed sequencer state");

    a_result_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> (out_valid_reg && $stable(res_line_reg)
                                               && $stable(res_mode_reg)))
        else $error("pending result lost while stalled");
`endif

endmodule

`default_nettype wire
